### hw/rtl/pbap_pkg.sv
// Types, codes and character helpers for the PLC bit address parser.
package pbap_pkg;

  typedef enum logic [3:0] {
    PH_START      = 4'd0,
    PH_AFTER_D    = 4'd1,
    PH_AREA       = 4'd2,
    PH_PREFIX     = 4'd3,
    PH_BYTE_FIRST = 4'd4,
    PH_BYTE_DIG   = 4'd5,
    PH_BIT_FIRST  = 4'd6,
    PH_BIT_DIG    = 4'd7,
    PH_ERROR      = 4'd8
  } phase_e;

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_EMPTY      = 4'd1,
    ST_DATA_BLOCK = 4'd2,
    ST_NO_AREA    = 4'd3,
    ST_BAD_AREA   = 4'd4,
    ST_WIDE       = 4'd5,
    ST_NO_BYTE    = 4'd6,
    ST_BYTE_MISS  = 4'd7,
    ST_NO_DOT     = 4'd8,
    ST_BAD_SEP    = 4'd9,
    ST_NO_BIT     = 4'd10,
    ST_TRAILING   = 4'd11,
    ST_BIT_RANGE  = 4'd12
  } status_e;

  typedef enum logic [1:0] {
    AREA_INPUT  = 2'd0,
    AREA_OUTPUT = 2'd1,
    AREA_MARKER = 2'd2
  } area_e;

  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChDot     = 8'h2E;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChUpA     = 8'h41;
  localparam logic [7:0] ChUpB     = 8'h42;
  localparam logic [7:0] ChUpD     = 8'h44;
  localparam logic [7:0] ChUpE     = 8'h45;
  localparam logic [7:0] ChUpI     = 8'h49;
  localparam logic [7:0] ChUpM     = 8'h4D;
  localparam logic [7:0] ChUpQ     = 8'h51;
  localparam logic [7:0] ChUpW     = 8'h57;
  localparam logic [7:0] ChUpX     = 8'h58;
  localparam logic [7:0] ChLowA    = 8'h61;
  localparam logic [7:0] ChLowZ    = 8'h7A;
  localparam logic [7:0] ChCaseGap = 8'h20;
  localparam logic [7:0] ChNine    = 8'h39;

  function automatic logic is_blank(input logic [7:0] c);
    return c inside {ChSpace, [8'h09:8'h0D]};
  endfunction

  function automatic logic dec_digit(input logic [7:0] c);
    return c inside {[ChZero:ChNine]};
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return (c inside {[ChLowA:ChLowZ]}) ? c - ChCaseGap : c;
  endfunction

  // The error that a single blank raises in each phase once text has begun.
  function automatic status_e blank_error(input phase_e ph);
    status_e st;
    case (ph)
      PH_AFTER_D, PH_AREA:        st = ST_BAD_AREA;
      PH_PREFIX, PH_BYTE_FIRST:   st = ST_NO_BYTE;
      PH_BYTE_DIG:                st = ST_BAD_SEP;
      PH_BIT_FIRST:               st = ST_NO_BIT;
      PH_BIT_DIG:                 st = ST_TRAILING;
      default:                    st = ST_OK;
    endcase
    return st;
  endfunction

endpackage

### hw/rtl/plc_bit_address_parser.sv
// PLC bit address parser: character input register, phase machine and result register.
// Order: a character taken into the input register is parsed into the phase state as it
//   leaves it; a result is registered when its final character leaves the input register.
// Throughput: one character per cycle, set by the single pass through the phase logic
//   and the times-ten accumulate; a waiting result stalls input only at a final character.
// Reset: asynchronous, active low; clears the input and result valids and the parse state.
module plc_bit_address_parser
  import pbap_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  character_i,
  input  logic        final_char_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  status_o,
  output logic [1:0]  area_o,
  output logic [31:0] byte_offset_o,
  output logic [2:0]  bit_index_o
);

  // Input register.
  logic       s1_valid_q;
  logic [7:0] s1_char_q;
  logic       s1_last_q;
  logic       s1_move;
  logic       in_take;

  // Parse state.
  phase_e      phase_q, phase_d;
  logic [31:0] acc_q, acc_d;
  logic [1:0]  area_q, area_d;
  logic [31:0] byte_q, byte_d;
  status_e     err_q, err_d;
  logic        pend_q, pend_d;

  // Result register.
  logic        out_valid_q;
  logic [3:0]  status_q, status_d;
  logic [1:0]  res_area_q, res_area_d;
  logic [31:0] res_byte_q, res_byte_d;
  logic [2:0]  res_bit_q, res_bit_d;

  logic [7:0]  upc;
  logic [3:0]  dig;
  logic [35:0] mac;
  logic        mac_ovf;
  logic        area_ok;
  logic [1:0]  area_code;
  status_e     end_st;

  // A final character may only advance when the result register can take it.
  assign s1_move    = s1_valid_q && !(s1_last_q && out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_move;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take || s1_move) begin
      s1_valid_q <= in_take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_char_q <= character_i;
      s1_last_q <= final_char_i;
    end
  end

  assign upc     = to_upper(s1_char_q);
  assign dig     = 4'(s1_char_q - ChZero);
  assign mac     = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + {32'd0, dig};
  assign mac_ovf = |mac[35:32];

  always_comb begin
    area_ok   = 1'b1;
    area_code = AREA_INPUT;
    if (upc == ChUpI || upc == ChUpE) begin
      area_code = AREA_INPUT;
    end else if (upc == ChUpQ || upc == ChUpA) begin
      area_code = AREA_OUTPUT;
    end else if (upc == ChUpM) begin
      area_code = AREA_MARKER;
    end else begin
      area_ok = 1'b0;
    end
  end

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    area_d  = area_q;
    byte_d  = byte_q;
    err_d   = err_q;
    pend_d  = pend_q;
    if (is_blank(s1_char_q)) begin
      if (phase_q != PH_START) begin
        pend_d = 1'b1;
      end
    end else if (pend_q && phase_q != PH_ERROR) begin
      // One held blank always fails; the character after it is then ignored.
      pend_d  = 1'b0;
      phase_d = PH_ERROR;
      err_d   = blank_error(phase_q);
    end else begin
      pend_d = 1'b0;
      case (phase_q)
        PH_START: begin
          if (upc == ChUpD) begin
            phase_d = PH_AFTER_D;
          end else if (s1_char_q == ChPercent) begin
            phase_d = PH_AREA;
          end else if (area_ok) begin
            area_d  = area_code;
            phase_d = PH_PREFIX;
          end else begin
            phase_d = PH_ERROR;
            err_d   = ST_BAD_AREA;
          end
        end
        PH_AFTER_D: begin
          phase_d = PH_ERROR;
          err_d   = (upc == ChUpB) ? ST_DATA_BLOCK : ST_BAD_AREA;
        end
        PH_AREA: begin
          if (area_ok) begin
            area_d  = area_code;
            phase_d = PH_PREFIX;
          end else begin
            phase_d = PH_ERROR;
            err_d   = ST_BAD_AREA;
          end
        end
        PH_PREFIX, PH_BYTE_FIRST: begin
          if (phase_q == PH_PREFIX && upc == ChUpX) begin
            phase_d = PH_BYTE_FIRST;
          end else if (phase_q == PH_PREFIX &&
                       (upc == ChUpB || upc == ChUpW || upc == ChUpD)) begin
            phase_d = PH_ERROR;
            err_d   = ST_WIDE;
          end else if (dec_digit(s1_char_q)) begin
            acc_d   = {28'd0, dig};
            phase_d = PH_BYTE_DIG;
          end else begin
            phase_d = PH_ERROR;
            err_d   = ST_NO_BYTE;
          end
        end
        PH_BYTE_DIG: begin
          if (dec_digit(s1_char_q)) begin
            if (mac_ovf) begin
              phase_d = PH_ERROR;
              err_d   = ST_NO_BYTE;
            end else begin
              acc_d = mac[31:0];
            end
          end else if (s1_char_q == ChDot) begin
            byte_d  = acc_q;
            acc_d   = '0;
            phase_d = PH_BIT_FIRST;
          end else begin
            phase_d = PH_ERROR;
            err_d   = ST_BAD_SEP;
          end
        end
        PH_BIT_FIRST: begin
          if (dec_digit(s1_char_q)) begin
            acc_d   = {28'd0, dig};
            phase_d = PH_BIT_DIG;
          end else begin
            phase_d = PH_ERROR;
            err_d   = ST_NO_BIT;
          end
        end
        PH_BIT_DIG: begin
          if (dec_digit(s1_char_q)) begin
            if (mac_ovf) begin
              phase_d = PH_ERROR;
              err_d   = ST_NO_BIT;
            end else begin
              acc_d = mac[31:0];
            end
          end else begin
            phase_d = PH_ERROR;
            err_d   = ST_TRAILING;
          end
        end
        default: begin
        end
      endcase
    end

    case (phase_d)
      PH_START:                 end_st = ST_EMPTY;
      PH_AFTER_D:               end_st = ST_BAD_AREA;
      PH_AREA:                  end_st = ST_NO_AREA;
      PH_PREFIX, PH_BYTE_FIRST: end_st = ST_BYTE_MISS;
      PH_BYTE_DIG:              end_st = ST_NO_DOT;
      PH_BIT_FIRST:             end_st = ST_NO_BIT;
      PH_BIT_DIG:               end_st = (acc_d > 32'd7) ? ST_BIT_RANGE : ST_OK;
      default:                  end_st = err_d;
    endcase

    status_d   = end_st;
    res_area_d = (end_st == ST_OK) ? area_d : 2'd0;
    res_byte_d = (end_st == ST_OK) ? byte_d : 32'd0;
    res_bit_d  = (end_st == ST_OK) ? acc_d[2:0] : 3'd0;

    // The text ends here: start over for the next address.
    if (s1_last_q) begin
      phase_d = PH_START;
      err_d   = ST_OK;
      pend_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      err_q   <= ST_OK;
      pend_q  <= 1'b0;
      acc_q   <= '0;
      area_q  <= '0;
      byte_q  <= '0;
    end else if (s1_move) begin
      phase_q <= phase_d;
      err_q   <= err_d;
      pend_q  <= pend_d;
      acc_q   <= acc_d;
      area_q  <= area_d;
      byte_q  <= byte_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move && s1_last_q) begin
      status_q   <= status_d;
      res_area_q <= res_area_d;
      res_byte_q <= res_byte_d;
      res_bit_q  <= res_bit_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign area_o        = res_area_q;
  assign byte_offset_o = res_byte_q;
  assign bit_index_o   = res_bit_q;

`ifndef ASSERT_OFF
  a_final_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move && s1_last_q |=> out_valid_o)
    else $error("final character did not produce a result");

  a_error_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> area_o == 2'd0 && byte_offset_o == 32'd0 &&
      bit_index_o == 3'd0)
    else $error("error result carries nonzero fields");

  a_ok_area_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_OK |-> area_o != 2'd3)
    else $error("successful result has an undefined area");

  a_no_blank_at_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_START |-> !pend_q)
    else $error("held blank before any text");

  a_restart_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move && s1_last_q |=> phase_q == PH_START)
    else $error("parser did not restart after the final character");
`endif

endmodule

### dv/testbench.sv
// Self-checking testbench for the PLC bit address parser, directed and random traffic.
module testbench;
  import pbap_pkg::*;

  typedef logic [7:0] text_q_t[$];

  typedef struct {
    status_e     status;
    area_e       area;
    logic [31:0] byte_off;
    logic [2:0]  bit_idx;
  } addr_result_t;

  localparam int CycleLimit = 200000;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic [7:0]  character_i  = 8'h00;
  logic        final_char_i = 1'b0;
  logic        out_stall_i  = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [3:0]  status_o;
  logic [1:0]  area_o;
  logic [31:0] byte_offset_o;
  logic [2:0]  bit_index_o;

  // Predicted parser state.
  phase_e      ph       = PH_START;
  logic [31:0] acc      = '0;
  area_e       area_q   = AREA_INPUT;
  logic [31:0] byte_q   = '0;
  status_e     err_q    = ST_OK;
  logic        blank_q  = 1'b0;

  addr_result_t expected_addr_q[$];

  int          idle_pct        = 17;
  int          stall_pct       = 17;
  int          fail_count      = 0;
  int          chars_sent      = 0;
  int          addresses_sent  = 0;
  int          results_checked = 0;
  int          cycle_count     = 0;
  logic [12:0] status_hit      = '0;

  plc_bit_address_parser uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .character_i   (character_i),
    .final_char_i  (final_char_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .area_o        (area_o),
    .byte_offset_o (byte_offset_o),
    .bit_index_o   (bit_index_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic blank_char(input logic [7:0] c);
    return c == ChSpace || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic digit_char(input logic [7:0] c);
    return c >= ChZero && c <= ChNine;
  endfunction

  // Bit 32 of the return flags a 32-bit overflow.
  function automatic logic [32:0] times_ten_plus(input logic [31:0] v, input logic [7:0] c);
    logic [31:0] d;
    d = 32'(c - ChZero);
    if (v > (32'hFFFF_FFFF - d) / 32'd10) return {1'b1, v};
    return {1'b0, v * 32'd10 + d};
  endfunction

  task automatic fail_parse(input status_e st);
    err_q = st;
    ph    = PH_ERROR;
  endtask

  task automatic take_area(input logic [7:0] u);
    if (u == ChUpI || u == ChUpE) begin
      area_q = AREA_INPUT;
      ph     = PH_PREFIX;
    end else if (u == ChUpQ || u == ChUpA) begin
      area_q = AREA_OUTPUT;
      ph     = PH_PREFIX;
    end else if (u == ChUpM) begin
      area_q = AREA_MARKER;
      ph     = PH_PREFIX;
    end else begin
      fail_parse(ST_BAD_AREA);
    end
  endtask

  task automatic begin_number(input logic [7:0] c, input phase_e next_ph, input status_e st);
    if (digit_char(c)) begin
      acc = 32'(c - ChZero);
      ph  = next_ph;
    end else begin
      fail_parse(st);
    end
  endtask

  task automatic more_digits(input logic [7:0] c, input status_e st);
    logic [32:0] sum;
    sum = times_ten_plus(acc, c);
    if (sum[32]) fail_parse(st);
    else acc = sum[31:0];
  endtask

  task automatic feed_char(input logic [7:0] c);
    logic [7:0] u;
    u = (c >= ChLowA && c <= ChLowZ) ? c - ChCaseGap : c;
    case (ph)
      PH_START: begin
        if (u == ChUpD) ph = PH_AFTER_D;
        else if (c == ChPercent) ph = PH_AREA;
        else take_area(u);
      end
      PH_AFTER_D:    fail_parse(u == ChUpB ? ST_DATA_BLOCK : ST_BAD_AREA);
      PH_AREA:       take_area(u);
      PH_PREFIX: begin
        if (u == ChUpX) ph = PH_BYTE_FIRST;
        else if (u == ChUpB || u == ChUpW || u == ChUpD) fail_parse(ST_WIDE);
        else begin_number(c, PH_BYTE_DIG, ST_NO_BYTE);
      end
      PH_BYTE_FIRST: begin_number(c, PH_BYTE_DIG, ST_NO_BYTE);
      PH_BYTE_DIG: begin
        if (digit_char(c)) more_digits(c, ST_NO_BYTE);
        else if (c == ChDot) begin
          byte_q = acc;
          acc    = '0;
          ph     = PH_BIT_FIRST;
        end else fail_parse(ST_BAD_SEP);
      end
      PH_BIT_FIRST:  begin_number(c, PH_BIT_DIG, ST_NO_BIT);
      PH_BIT_DIG: begin
        if (digit_char(c)) more_digits(c, ST_NO_BIT);
        else fail_parse(ST_TRAILING);
      end
      default: ;
    endcase
  endtask

  task automatic parse_char(input logic [7:0] c, input logic fin);
    addr_result_t res;
    if (blank_char(c)) begin
      if (ph != PH_START) blank_q = 1'b1;
    end else begin
      // A run of blanks inside the text acts as one space.
      if (blank_q) begin
        feed_char(ChSpace);
        blank_q = 1'b0;
      end
      feed_char(c);
    end
    if (fin) begin
      case (ph)
        PH_START:                 res.status = ST_EMPTY;
        PH_AFTER_D:               res.status = ST_BAD_AREA;
        PH_AREA:                  res.status = ST_NO_AREA;
        PH_PREFIX, PH_BYTE_FIRST: res.status = ST_BYTE_MISS;
        PH_BYTE_DIG:              res.status = ST_NO_DOT;
        PH_BIT_FIRST:             res.status = ST_NO_BIT;
        PH_BIT_DIG:               res.status = acc > 32'd7 ? ST_BIT_RANGE : ST_OK;
        default:                  res.status = err_q;
      endcase
      if (res.status == ST_OK) begin
        res.area     = area_q;
        res.byte_off = byte_q;
        res.bit_idx  = acc[2:0];
      end else begin
        res.area     = AREA_INPUT;
        res.byte_off = '0;
        res.bit_idx  = '0;
      end
      expected_addr_q.push_back(res);
      ph      = PH_START;
      acc     = '0;
      area_q  = AREA_INPUT;
      byte_q  = '0;
      err_q   = ST_OK;
      blank_q = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------- result side

  always @(negedge clk_i)
    out_stall_i <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

  always @(posedge clk_i) begin
    addr_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_addr_q.size() == 0) begin
        $display("%0t: result with nothing expected: status=%0d area=%0d byte=%0d bit=%0d",
                 $time, status_o, area_o, byte_offset_o, bit_index_o);
        fail_count++;
      end else begin
        want = expected_addr_q.pop_front();
        results_checked++;
        if (status_o !== want.status || area_o !== want.area ||
            byte_offset_o !== want.byte_off || bit_index_o !== want.bit_idx) begin
          $display("%0t: mismatch expected status=%0d area=%0d byte=%0d bit=%0d",
                   $time, want.status, want.area, want.byte_off, want.bit_idx);
          $display("%0t:          actual   status=%0d area=%0d byte=%0d bit=%0d",
                   $time, status_o, area_o, byte_offset_o, bit_index_o);
          fail_count++;
        end else begin
          status_hit[want.status] = 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------- sender

  task automatic send_char(input logic [7:0] ch, input logic fin);
    @(negedge clk_i);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    character_i  <= ch;
    final_char_i <= fin;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    parse_char(ch, fin);
    chars_sent++;
  endtask

  task automatic send_bytes(input text_q_t txt);
    foreach (txt[i]) send_char(txt[i], i == txt.size() - 1);
    addresses_sent++;
  endtask

  task automatic send_str(input string s);
    text_q_t txt;
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
    send_bytes(txt);
  endtask

  task automatic wait_results_done();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_addr_q.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- random text

  function automatic logic [7:0] pick_blank();
    int n;
    n = $urandom_range(0, 5);
    return n == 5 ? ChSpace : 8'(8'h09 + n);
  endfunction

  function automatic text_q_t dec_text(input logic [63:0] v);
    text_q_t q;
    do begin
      q.push_front(8'(ChZero + v % 10));
      v = v / 10;
    end while (v != 0);
    return q;
  endfunction

  function automatic logic [7:0] maybe_lower(input logic [7:0] c);
    return $urandom_range(1) ? c | ChCaseGap : c;
  endfunction

  function automatic text_q_t make_address();
    text_q_t     txt;
    logic [7:0]  letters[5];
    logic [63:0] val;
    int          n;
    letters = '{ChUpI, ChUpE, ChUpQ, ChUpA, ChUpM};
    if ($urandom_range(99) < 6) begin
      n = $urandom_range(1, 6);
      repeat (n) txt.push_back(8'($urandom));
      return txt;
    end
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) txt.push_back(pick_blank());
    if ($urandom_range(99) < 3) begin
      txt.push_back(maybe_lower(ChUpD));
      txt.push_back($urandom_range(1) ? maybe_lower(ChUpB) : 8'($urandom));
      return txt;
    end
    if ($urandom_range(1)) txt.push_back(ChPercent);
    if ($urandom_range(99) < 5) txt.push_back(8'($urandom));
    else txt.push_back(maybe_lower(letters[$urandom_range(0, 4)]));
    n = $urandom_range(99);
    if (n < 4) txt.push_back(maybe_lower($urandom_range(1) ? ChUpW : ChUpB));
    else if (n < 34) txt.push_back(maybe_lower(ChUpX));
    case ($urandom_range(9))
      6:       val = 64'($urandom);
      7:       val = 64'(32'hFFFF_FFFF - $urandom_range(0, 9));
      8:       val = 64'h1_0000_0000 + $urandom_range(0, 1000);
      9:       val = 64'($urandom_range(0, 99999));
      default: val = 64'($urandom_range(0, 999));
    endcase
    if ($urandom_range(9) == 0) repeat ($urandom_range(1, 3)) txt.push_back(ChZero);
    txt = {txt, dec_text(val)};
    txt.push_back($urandom_range(99) < 97 ? ChDot : 8'($urandom));
    n = $urandom_range(99);
    if (n < 88) val = 64'($urandom_range(0, 7));
    else if (n < 96) val = 64'($urandom_range(8, 999));
    else val = 64'h1_0000_0000 + $urandom_range(0, 50);
    if ($urandom_range(19) == 0) txt.push_back(ChZero);
    txt = {txt, dec_text(val)};
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) txt.push_back(pick_blank());
    // Break some of the well-formed addresses.
    if ($urandom_range(99) < 18) begin
      n = $urandom_range(0, txt.size() - 1);
      case ($urandom_range(2))
        0: txt[n] = 8'($urandom);
        1: txt = txt[0:n];
        default: txt.insert(n, pick_blank());
      endcase
    end
    return txt;
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_statuses();
    send_str("%I10.2");
    send_str(" ");
    send_str("db1");
    send_str("%");
    send_str("Z1.0");
    send_str("D");
    send_str("MW4");
    send_str("IX");
    send_str("I");
    send_str("IA");
    send_str("I12");
    send_str("I1,2");
    send_str("I1.");
    send_str("I1.2a");
    send_str("I1.9");
  endtask

  task automatic test_blanks_and_case();
    send_str("\t %qx3.4 \r\n");
    send_str("%m 7.3");
    send_str("I1 .0");
    send_str("I1. 2");
    send_str("e5.1  x");
    send_str("% I1.1");
    send_str("D B");
    send_str("\013\014a0.0\013");
  endtask

  task automatic test_limits();
    send_str("M4294967295.7");
    send_str("M4294967296.0");
    send_str("I0.99999999999");
    send_str("\377");
    send_str("I1.2\200");
    send_str("%IX000.00");
  endtask

  task automatic test_random_traffic(input int n_chars);
    int stop_at;
    stop_at = chars_sent + n_chars;
    while (chars_sent < stop_at) send_bytes(make_address());
  endtask

  task automatic test_steady_stream(input int n_chars);
    idle_pct  = 0;
    stall_pct = 0;
    test_random_traffic(n_chars);
    idle_pct  = 17;
    stall_pct = 17;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_statuses();
    test_blanks_and_case();
    test_limits();
    test_random_traffic(400);
    // Hold the input back until the result side has fully drained.
    wait_results_done();
    test_steady_stream(250);
    test_random_traffic(300);

    wait_results_done();
    repeat (4) @(posedge clk_i);
    $display("Sent %0d addresses (%0d characters), checked %0d results.",
             addresses_sent, chars_sent, results_checked);
    $display("Distinct status codes matched: %0d of 13.", $countones(status_hit));
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
